// ----- hw/rtl/tmf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch median filter package
// Shared types and constants for the touch front end and its checker.
// ----------------------------------------------------------------------------
package tmf_pkg;

    // Default number of samples per axis in one batch
    localparam int SAMPLES_PER_AXIS_DEF = 7;

    // Converter word width and arrival counter
    localparam int WORD_W    = 24;
    localparam int COUNT_W   = 4;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 4'hf;

    // Request channel layout
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 2;
    localparam int S_PEN_BIT = WORD_W;

    // Result channel layout
    localparam int M_START_BIT = 0;
    localparam int M_PRESS_BIT = 1;
    localparam int M_X_LSB     = 2;
    localparam int M_Y_LSB     = M_X_LSB + WORD_W;
    localparam int M_ERR_BIT   = M_Y_LSB + WORD_W;
    localparam int M_TDATA_W   = 56;
    localparam int M_PAD_W     = M_TDATA_W - (M_ERR_BIT + 1);

    // Request kinds
    typedef enum logic [S_TUSER_W-1:0] {
        ACT_TOUCH  = 2'd0,
        ACT_SAMPLE = 2'd1,
        ACT_POLL   = 2'd2
    } action_t;

endpackage

// ----- hw/rtl/touch_median_filter_tracker_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch median filter tracker core
// Collects a batch of X and Y converter words, takes the median of each axis
// with one shared comparator and reports changed pen positions.
// ----------------------------------------------------------------------------
// Results: touch, sample, idle poll and overfull poll give their result in the
//   cycle after acceptance. A poll on a full batch runs the median sequencer,
//   which makes one comparison per cycle on the store's single read port.
// Throughput: one request at a time; s_tready is low while the sequencer runs
//   or while a result waits in the output register.
// Reset: rst_n (async, active low) returns to waiting for touch, clears the
//   count, the last reported position and the output register. The sample
//   store is not cleared; only entries of the current batch are read.
// ----------------------------------------------------------------------------
module touch_median_filter_tracker_core
    import tmf_pkg::*;
#(
    parameter int SAMPLES_PER_AXIS = SAMPLES_PER_AXIS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    // Request channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [23:0] sample_word, [24] pen_is_down, rest 0
    input  logic [S_TUSER_W-1:0] s_tuser,   // [1:0] action

    // Result channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [0] start_batch, [1] pressure,
                                            // [25:2] x_position, [49:26] y_position,
                                            // [50] count_error, rest 0
    output logic                 m_tuser    // [0] report_valid
);

    // ------------------------------------------------------------------------
    // Derived sizes
    // ------------------------------------------------------------------------
    localparam int BATCH_N = 2 * SAMPLES_PER_AXIS;
    localparam int ADDR_W  = $clog2(BATCH_N);
    localparam int IDX_W   = $clog2(SAMPLES_PER_AXIS);
    localparam int CNT_W   = $clog2(SAMPLES_PER_AXIS + 1);
    localparam int MID     = SAMPLES_PER_AXIS / 2;

    localparam logic [COUNT_W-1:0] BATCH    = COUNT_W'(BATCH_N);
    localparam logic [IDX_W-1:0]   IDX_LAST = IDX_W'(SAMPLES_PER_AXIS - 1);
    localparam logic [CNT_W-1:0]   RANK_MID = CNT_W'(MID);
    localparam logic [ADDR_W-1:0]  Y_BASE   = ADDR_W'(SAMPLES_PER_AXIS);

    // Median sequencer states
    typedef enum logic [2:0] {
        SEQ_IDLE,   // take requests
        SEQ_LOAD,   // read the candidate word
        SEQ_CAND,   // latch the candidate, start the scan
        SEQ_SCAN,   // compare one stored word per cycle against the candidate
        SEQ_CHECK,  // decide whether the candidate sits at the middle rank
        SEQ_DONE    // wait for the output register, then report
    } seq_state_t;

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    seq_state_t          state_reg;
    logic                sampling_reg;     // touch seen, batch collection active
    logic [COUNT_W-1:0]  count_reg;
    logic [WORD_W-1:0]   last_x_reg;
    logic [WORD_W-1:0]   last_y_reg;
    logic                pen_reg;          // pen level captured with the poll

    logic                axis_reg;         // 0 X half of the store, 1 Y half
    logic [IDX_W-1:0]    cand_reg;
    logic [IDX_W-1:0]    scan_reg;
    logic [WORD_W-1:0]   cand_val_reg;
    logic [CNT_W-1:0]    lt_cnt_reg;       // stored words below the candidate
    logic [CNT_W-1:0]    le_cnt_reg;       // stored words at or below the candidate
    logic [WORD_W-1:0]   med_x_reg;
    logic [WORD_W-1:0]   med_y_reg;

    logic                m_tvalid_reg;
    logic                out_start_reg;
    logic                out_report_reg;
    logic                out_press_reg;
    logic [WORD_W-1:0]   out_x_reg;
    logic [WORD_W-1:0]   out_y_reg;
    logic                out_err_reg;

    // Sample store with one write and one registered read port
    logic [WORD_W-1:0]   store_mem [BATCH_N];
    logic [WORD_W-1:0]   rd_data_reg;

    // ------------------------------------------------------------------------
    // Request decode
    // ------------------------------------------------------------------------
    logic                out_free;
    logic                s_fire;
    logic [WORD_W-1:0]   in_word;
    logic                in_pen;
    action_t             in_action;
    logic                full_poll;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == SEQ_IDLE) && out_free;
    assign s_fire    = s_tvalid && s_tready;
    assign in_word   = s_tdata[WORD_W-1:0];
    assign in_pen    = s_tdata[S_PEN_BIT];
    assign in_action = action_t'(s_tuser);

    // A poll on a complete batch starts the sequencer instead of reporting
    assign full_poll = (in_action == ACT_POLL) && sampling_reg && (count_reg == BATCH);

    // Store a sample while collecting and while the batch still has room
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;

    assign wr_en   = s_fire && (in_action == ACT_SAMPLE) && sampling_reg
                     && (count_reg < BATCH);
    assign wr_addr = count_reg[ADDR_W-1:0];

    // ------------------------------------------------------------------------
    // Read address: candidate in LOAD, first word in CAND, next word in SCAN
    // ------------------------------------------------------------------------
    logic [IDX_W-1:0]    rd_idx;
    logic [ADDR_W-1:0]   rd_addr;

    always_comb
    begin
        case (state_reg)
            SEQ_LOAD: rd_idx = cand_reg;
            SEQ_SCAN: rd_idx = (scan_reg == IDX_LAST) ? '0 : scan_reg + IDX_W'(1);
            default:  rd_idx = '0;
        endcase
    end

    assign rd_addr = (axis_reg ? Y_BASE : '0) + ADDR_W'(rd_idx);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= in_word;
        end
        rd_data_reg <= store_mem[rd_addr];
    end

    // ------------------------------------------------------------------------
    // Shared comparator: stored word against the candidate
    // ------------------------------------------------------------------------
    logic cmp_lt;
    logic cmp_le;

    assign cmp_lt = rd_data_reg < cand_val_reg;
    assign cmp_le = cmp_lt || (rd_data_reg == cand_val_reg);

    // Candidate is the median when at most MID words lie below it and more
    // than MID words lie at or below it
    logic is_median;

    assign is_median = (lt_cnt_reg <= RANK_MID) && (le_cnt_reg > RANK_MID);

    // Position change test for the pen-down report
    logic pos_changed;

    assign pos_changed = (med_x_reg != last_x_reg) || (med_y_reg != last_y_reg);

    // ------------------------------------------------------------------------
    // Sequencer, tracker state and output register
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= SEQ_IDLE;
            sampling_reg   <= 1'b0;
            count_reg      <= '0;
            last_x_reg     <= '0;
            last_y_reg     <= '0;
            pen_reg        <= 1'b0;
            axis_reg       <= 1'b0;
            cand_reg       <= '0;
            scan_reg       <= '0;
            cand_val_reg   <= '0;
            lt_cnt_reg     <= '0;
            le_cnt_reg     <= '0;
            med_x_reg      <= '0;
            med_y_reg      <= '0;
            m_tvalid_reg   <= 1'b0;
            out_start_reg  <= 1'b0;
            out_report_reg <= 1'b0;
            out_press_reg  <= 1'b0;
            out_x_reg      <= '0;
            out_y_reg      <= '0;
            out_err_reg    <= 1'b0;
        end
        else
        begin
            // Drop the result once the downstream side takes it, unless a new
            // request replaces it in the same cycle
            if (m_tvalid_reg && m_tready && !s_fire)
            begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                SEQ_IDLE:
                begin
                    if (s_fire)
                    begin
                        // Default result: all fields zero; a full-batch poll
                        // holds it back until the medians exist
                        m_tvalid_reg   <= !full_poll;
                        out_start_reg  <= 1'b0;
                        out_report_reg <= 1'b0;
                        out_press_reg  <= 1'b0;
                        out_x_reg      <= '0;
                        out_y_reg      <= '0;
                        out_err_reg    <= 1'b0;

                        case (in_action)
                            ACT_TOUCH:
                            begin
                                // Leave idle and request the first batch
                                if (!sampling_reg)
                                begin
                                    sampling_reg  <= 1'b1;
                                    count_reg     <= '0;
                                    out_start_reg <= 1'b1;
                                end
                            end
                            ACT_SAMPLE:
                            begin
                                // Advance the arrival count, saturating
                                if (sampling_reg && (count_reg < COUNT_MAX))
                                begin
                                    count_reg <= count_reg + COUNT_W'(1);
                                end
                            end
                            ACT_POLL:
                            begin
                                if (sampling_reg && (count_reg > BATCH))
                                begin
                                    // Overfull batch: flag it and restart or stop
                                    out_err_reg   <= 1'b1;
                                    count_reg     <= '0;
                                    out_start_reg <= in_pen;
                                    sampling_reg  <= in_pen;
                                end
                                else if (full_poll)
                                begin
                                    // Full batch: start the median sequencer
                                    count_reg    <= '0;
                                    pen_reg      <= in_pen;
                                    axis_reg     <= 1'b0;
                                    cand_reg     <= '0;
                                    state_reg    <= SEQ_LOAD;
                                end
                            end
                            default:
                            begin
                                // Unused code: zero result already set
                            end
                        endcase
                    end
                end

                SEQ_LOAD:
                begin
                    state_reg <= SEQ_CAND;
                end

                SEQ_CAND:
                begin
                    cand_val_reg <= rd_data_reg;
                    lt_cnt_reg   <= '0;
                    le_cnt_reg   <= '0;
                    scan_reg     <= '0;
                    state_reg    <= SEQ_SCAN;
                end

                SEQ_SCAN:
                begin
                    if (cmp_lt)
                    begin
                        lt_cnt_reg <= lt_cnt_reg + CNT_W'(1);
                    end
                    if (cmp_le)
                    begin
                        le_cnt_reg <= le_cnt_reg + CNT_W'(1);
                    end
                    if (scan_reg == IDX_LAST)
                    begin
                        state_reg <= SEQ_CHECK;
                    end
                    else
                    begin
                        scan_reg <= scan_reg + IDX_W'(1);
                    end
                end

                SEQ_CHECK:
                begin
                    if (is_median)
                    begin
                        if (!axis_reg)
                        begin
                            // X done, move on to the Y half
                            med_x_reg <= cand_val_reg;
                            axis_reg  <= 1'b1;
                            cand_reg  <= '0;
                            state_reg <= SEQ_LOAD;
                        end
                        else
                        begin
                            med_y_reg <= cand_val_reg;
                            state_reg <= SEQ_DONE;
                        end
                    end
                    else
                    begin
                        cand_reg  <= cand_reg + IDX_W'(1);
                        state_reg <= SEQ_LOAD;
                    end
                end

                SEQ_DONE:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg   <= 1'b1;
                        out_err_reg    <= 1'b0;
                        out_x_reg      <= '0;
                        out_y_reg      <= '0;
                        out_press_reg  <= 1'b0;
                        out_report_reg <= 1'b0;
                        if (pen_reg)
                        begin
                            // Pen down: report only a moved position, always re-arm
                            out_start_reg <= 1'b1;
                            if (pos_changed)
                            begin
                                last_x_reg     <= med_x_reg;
                                last_y_reg     <= med_y_reg;
                                out_report_reg <= 1'b1;
                                out_press_reg  <= 1'b1;
                                out_x_reg      <= med_x_reg;
                                out_y_reg      <= med_y_reg;
                            end
                        end
                        else
                        begin
                            // Pen up: release report, back to waiting for touch
                            out_start_reg  <= 1'b0;
                            out_report_reg <= 1'b1;
                            sampling_reg   <= 1'b0;
                        end
                        state_reg <= SEQ_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= SEQ_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Result channel
    // ------------------------------------------------------------------------
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_report_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, out_err_reg, out_y_reg, out_x_reg,
                       out_press_reg, out_start_reg};

endmodule

// ----- hw/rtl/tmf_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch median filter checker
// Port-level assertions on the result channel, bound to the core.
// ----------------------------------------------------------------------------
module tmf_checker
    import tmf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 m_tuser
);

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Without a report, pressure and position stay zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[M_ERR_BIT-1:M_PRESS_BIT] == '0)
        else $error("position fields set without a report");

    // A release report carries a zero position
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser && !m_tdata[M_PRESS_BIT]
        |-> m_tdata[M_ERR_BIT-1:M_X_LSB] == '0)
        else $error("release report with nonzero position");

    // A position report always re-arms the batch and never comes with an error
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[M_PRESS_BIT]
        |-> m_tdata[M_START_BIT] && m_tuser && !m_tdata[M_ERR_BIT])
        else $error("touch report without batch request");

endmodule

bind touch_median_filter_tracker_core tmf_checker u_tmf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- tb/sv/tb_touch_median_filter_tracker_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch median filter tracker core testbench
// Sends touch, sample and poll requests to the core in random bursts and
// checks every result against an in-bench tracker model. The model keeps its
// own sample store, count and last position. The result side stalls on
// changing patterns, including two long hold-offs that back up the core.
// ----------------------------------------------------------------------------
module tb_touch_median_filter_tracker_core;
    import tmf_pkg::*;

    localparam int AXIS_WORDS      = SAMPLES_PER_AXIS_DEF;
    localparam int BATCH_WORDS     = 2 * AXIS_WORDS;
    localparam int TARGET_REQUESTS = 1250;
    localparam int STALL_LIMIT     = 4000;   // cycles with no handshake at all
    localparam int DRAIN_CYCLES    = 200;    // longer than the worst median pass
    localparam int LONG_HOLD       = 600;
    localparam int HOLD_START_A    = 1500;
    localparam int HOLD_START_B    = 7000;
    localparam int MAX_SHOWN       = 10;

    // The request kind that the core must ignore
    localparam logic [S_TUSER_W-1:0] ACT_RESERVED = 2'd3;

    typedef struct packed {
        logic [S_TUSER_W-1:0] act;
        logic [WORD_W-1:0]    word;
        logic                 pen;
    } touch_req_t;

    typedef struct packed {
        logic              start_batch;
        logic              report_valid;
        logic              pressure;
        logic [WORD_W-1:0] x_position;
        logic [WORD_W-1:0] y_position;
        logic              count_error;
    } touch_report_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;  // [23:0] sample_word, [24] pen_is_down, rest 0
    logic [S_TUSER_W-1:0] s_tuser = '0;  // [1:0] action
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;       // [0] start_batch, [1] pressure,
                                         // [25:2] x_position, [49:26] y_position,
                                         // [50] count_error, rest 0
    logic                 m_tuser;       // [0] report_valid

    // Tracker model state, at its reset values
    logic                 trk_sampling = 1'b0;
    logic [WORD_W-1:0]    trk_store [BATCH_WORDS] = '{default: '0};
    logic [COUNT_W-1:0]   trk_count = '0;
    logic [WORD_W-1:0]    trk_last_x = '0;
    logic [WORD_W-1:0]    trk_last_y = '0;

    touch_req_t           pending_requests[$];
    touch_report_t        awaited_reports[$];
    touch_req_t           req_on_bus;
    logic [WORD_W-1:0]    prev_words [BATCH_WORDS] = '{default: '0};

    int fault_count   = 0;
    int requests_sent = 0;
    int results_seen  = 0;
    int positions     = 0;
    int releases      = 0;
    int overflows     = 0;
    int batch_starts  = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    touch_median_filter_tracker_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // ------------------------------------------------------------------------
    // Tracker model
    // ------------------------------------------------------------------------

    // Sort one axis of the store and pick the middle word.
    function automatic logic [WORD_W-1:0] axis_mid(input int base);
        logic [WORD_W-1:0] v [AXIS_WORDS];
        logic [WORD_W-1:0] t;
        for (int i = 0; i < AXIS_WORDS; i++)
            v[i] = trk_store[base + i];
        for (int i = 0; i < AXIS_WORDS - 1; i++)
            for (int j = 0; j < AXIS_WORDS - 1 - i; j++)
                if (v[j] > v[j + 1])
                begin
                    t        = v[j];
                    v[j]     = v[j + 1];
                    v[j + 1] = t;
                end
        return v[AXIS_WORDS / 2];
    endfunction

    // Advance the tracker by one request and return the result it causes.
    function automatic touch_report_t next_touch_report(input touch_req_t req);
        touch_report_t     rep;
        logic [WORD_W-1:0] mx;
        logic [WORD_W-1:0] my;
        rep = '0;
        case (req.act)
            ACT_TOUCH:
                // A touch edge only counts when waiting for one
                if (!trk_sampling)
                begin
                    trk_sampling    = 1'b1;
                    trk_count       = '0;
                    rep.start_batch = 1'b1;
                end
            ACT_SAMPLE:
                if (trk_sampling)
                begin
                    if (trk_count < BATCH_WORDS)
                        trk_store[trk_count] = req.word;
                    if (trk_count != COUNT_MAX)
                        trk_count = trk_count + 1'b1;
                end
            ACT_POLL:
                if (trk_sampling && trk_count > BATCH_WORDS)
                begin
                    // Too many words: drop the batch, restart only with the pen down
                    rep.count_error = 1'b1;
                    trk_count       = '0;
                    if (req.pen)
                        rep.start_batch = 1'b1;
                    else
                        trk_sampling = 1'b0;
                end
                else if (trk_sampling && trk_count == BATCH_WORDS)
                begin
                    mx        = axis_mid(0);
                    my        = axis_mid(AXIS_WORDS);
                    trk_count = '0;
                    if (req.pen)
                    begin
                        // Report only a moved position, but always ask for more
                        if (mx != trk_last_x || my != trk_last_y)
                        begin
                            trk_last_x       = mx;
                            trk_last_y       = my;
                            rep.report_valid = 1'b1;
                            rep.pressure     = 1'b1;
                            rep.x_position   = mx;
                            rep.y_position   = my;
                        end
                        rep.start_batch = 1'b1;
                    end
                    else
                    begin
                        // Pen lifted: zero report, back to waiting for touch
                        rep.report_valid = 1'b1;
                        trk_sampling     = 1'b0;
                    end
                end
            default:
                ;
        endcase
        return rep;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    task automatic push_req(input logic [S_TUSER_W-1:0] act, input logic [WORD_W-1:0] word,
                            input logic pen);
        touch_req_t r;
        r.act  = act;
        r.word = word;
        r.pen  = pen;
        pending_requests.push_back(r);
    endtask

    // Queue one batch of samples and its closing poll. An early poll before
    // word early_at hits an underfull batch; a negative early_at skips it.
    task automatic add_batch(input int n_words, input int early_at, input logic pen);
        logic [WORD_W-1:0] w [BATCH_WORDS];
        logic [WORD_W-1:0] base;
        logic [WORD_W-1:0] t;
        int                shape;
        int                k;
        shape = $urandom_range(0, 5);
        base  = WORD_W'($urandom);
        for (int i = 0; i < BATCH_WORDS; i++)
        begin
            case (shape)
                0, 1:    w[i] = WORD_W'($urandom);
                2:       w[i] = WORD_W'($urandom_range(0, 3));           // heavy ties
                3:       w[i] = $urandom_range(0, 1) ? {WORD_W{1'b1}} : '0;
                4:       w[i] = base + WORD_W'($urandom_range(0, 7));    // small jitter
                default: w[i] = prev_words[i];                           // same set again
            endcase
        end
        if (shape == 5)
        begin
            // Shuffle each axis so that the medians stay put
            for (int a = 0; a < 2; a++)
                for (int i = 0; i < AXIS_WORDS - 1; i++)
                begin
                    k = a * AXIS_WORDS + $urandom_range(i, AXIS_WORDS - 1);
                    t = w[a * AXIS_WORDS + i];
                    w[a * AXIS_WORDS + i] = w[k];
                    w[k] = t;
                end
        end
        prev_words = w;
        for (int i = 0; i < n_words; i++)
        begin
            if (i == early_at)
                push_req(ACT_POLL, WORD_W'($urandom), 1'($urandom));
            push_req(ACT_SAMPLE, (i < BATCH_WORDS) ? w[i] : WORD_W'($urandom),
                     1'($urandom));
        end
        push_req(ACT_POLL, WORD_W'($urandom), pen);
    endtask

    function automatic void report_fault(input string msg);
        if (fault_count < MAX_SHOWN)
            $display("[%0t] MISMATCH %s", $realtime, msg);
        fault_count++;
    endfunction

    function automatic void check_field(input string name, input logic [WORD_W-1:0] want,
                                        input logic [WORD_W-1:0] got);
        if (got !== want)
            report_fault($sformatf("result %0d %s: expected 0x%06h, got 0x%06h",
                                   results_seen, name, want, got));
    endfunction

    // ------------------------------------------------------------------------
    // Request driver: bursts of random length with random gaps between them
    // ------------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge clk or negedge rst_n)
    begin : request_driver
        touch_req_t nxt;
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            s_tuser    <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            // Predict as soon as the core takes the request
            if (s_tvalid && s_tready)
            begin
                awaited_reports.push_back(next_touch_report(req_on_bus));
                requests_sent++;
            end

            if (s_tvalid && !s_tready)
                ;   // hold the request until it is taken
            else if (gap_left != 0)
            begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end
            else if (pending_requests.size() != 0)
            begin
                nxt        = pending_requests.pop_front();
                req_on_bus = nxt;
                s_tvalid   <= 1'b1;
                s_tdata    <= {{(S_TDATA_W - WORD_W - 1){1'b0}}, nxt.pen, nxt.word};
                s_tuser    <= nxt.act;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 15);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Result-side stalls: segments of changing patterns, plus long hold-offs
    // that fill the core and push back on the request side
    // ------------------------------------------------------------------------
    int bp_cycle  = 0;
    int hold_left = 0;
    int seg_left  = 0;
    int seg_mode  = 0;

    always @(posedge clk or negedge rst_n)
    begin : result_backpressure
        logic take;
        take = 1'b1;
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            bp_cycle  <= 0;
            hold_left <= 0;
            seg_left  <= 0;
            seg_mode  <= 0;
        end
        else
        begin
            bp_cycle <= bp_cycle + 1;
            if (bp_cycle == HOLD_START_A || bp_cycle == HOLD_START_B)
            begin
                hold_left <= LONG_HOLD;
                take = 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                take = 1'b0;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    seg_mode <= $urandom_range(0, 3);
                    seg_left <= $urandom_range(10, 150);
                end
                else
                    seg_left <= seg_left - 1;
                case (seg_mode)
                    0:       take = 1'b1;
                    1:       take = ($urandom_range(0, 2) != 0);
                    2:       take = bp_cycle[0];
                    default: take = ($urandom_range(0, 3) == 0);
                endcase
            end
            m_tready <= take;
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: compare each taken result with the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : result_monitor
        touch_report_t got;
        touch_report_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.start_batch  = m_tdata[M_START_BIT];
            got.pressure     = m_tdata[M_PRESS_BIT];
            got.x_position   = m_tdata[M_X_LSB +: WORD_W];
            got.y_position   = m_tdata[M_Y_LSB +: WORD_W];
            got.count_error  = m_tdata[M_ERR_BIT];
            got.report_valid = m_tuser;
            if (awaited_reports.size() == 0)
                report_fault($sformatf("result %0d arrived with nothing awaited",
                                       results_seen));
            else
            begin
                want = awaited_reports.pop_front();
                check_field("start_batch", want.start_batch, got.start_batch);
                check_field("report_valid", want.report_valid, got.report_valid);
                check_field("pressure", want.pressure, got.pressure);
                check_field("x_position", want.x_position, got.x_position);
                check_field("y_position", want.y_position, got.y_position);
                check_field("count_error", want.count_error, got.count_error);
                if (want.report_valid && want.pressure)
                    positions++;
                if (want.report_valid && !want.pressure)
                    releases++;
                if (want.count_error)
                    overflows++;
                if (want.start_batch)
                    batch_starts++;
            end
            results_seen++;
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if nothing moves on either side for too long
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[%0t] timeout: no handshake for %0d cycles, %0d results awaited",
                 $realtime, STALL_LIMIT, awaited_reports.size());
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence: build the request list, reset, drain and report
    // ------------------------------------------------------------------------
    initial
    begin : main_seq
        logic [WORD_W-1:0] corner_words [BATCH_WORDS];
        int                n_batches;
        int                roll;
        logic              pen;

        // X median lands on the midpoint word, Y median on the word below it
        corner_words = '{24'h000000, 24'hffffff, 24'h000000, 24'hffffff,
                         24'h800000, 24'hffffff, 24'h000001,
                         24'hffffff, 24'hffffff, 24'hffffff, 24'h000000,
                         24'h000000, 24'h000000, 24'h7fffff};

        // Directed: ignored requests in idle, a second touch while sampling,
        // an underfull poll halfway through and a full batch of corner words
        push_req(ACT_POLL, '0, 1'b1);
        push_req(ACT_SAMPLE, {WORD_W{1'b1}}, 1'b1);
        push_req(ACT_RESERVED, {WORD_W{1'b1}}, 1'b1);
        push_req(ACT_TOUCH, '0, 1'b0);
        push_req(ACT_TOUCH, {WORD_W{1'b1}}, 1'b1);
        for (int i = 0; i < BATCH_WORDS; i++)
        begin
            if (i == AXIS_WORDS)
                push_req(ACT_POLL, '0, 1'b1);
            push_req(ACT_SAMPLE, corner_words[i], i[0]);
        end
        push_req(ACT_POLL, {WORD_W{1'b1}}, 1'b1);

        // Random: touch sessions of a few batches, mostly well formed, with
        // overfull and underfull batches and some stray requests between them
        while (pending_requests.size() < TARGET_REQUESTS)
        begin
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 4))
                    push_req(S_TUSER_W'($urandom_range(0, 3)), WORD_W'($urandom),
                             1'($urandom));
            push_req(ACT_TOUCH, WORD_W'($urandom), 1'($urandom));
            n_batches = $urandom_range(1, 6);
            for (int b = 0; b < n_batches; b++)
            begin
                // Lift the pen at the end of most sessions
                pen  = (b == n_batches - 1) ? ($urandom_range(0, 3) == 0) : 1'b1;
                roll = $urandom_range(0, 99);
                if (roll < 12)
                    add_batch($urandom_range(BATCH_WORDS + 1, BATCH_WORDS + 4), -1, pen);
                else if (roll < 22)
                    add_batch(BATCH_WORDS, $urandom_range(0, BATCH_WORDS - 1), pen);
                else
                    add_batch(BATCH_WORDS, -1, pen);
            end
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every request to go out, then for every result to return
        while (pending_requests.size() != 0 || s_tvalid)
            @(posedge clk);
        while (awaited_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d requests and %0d results: %0d position reports, %0d releases,",
                 requests_sent, results_seen, positions, releases);
        $display("  %0d overfull batches, %0d batch starts; %0d mismatches",
                 overflows, batch_starts, fault_count);
        if (fault_count == 0 && awaited_reports.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
